// ===== rtl/prst_pkg.sv =====
// ----------------------------------------------------------------------------
// prst_pkg: shared types and constants for the point transform block
// Word layouts, command codes, datapath widths and the cordic angle table.
// ----------------------------------------------------------------------------
package prst_pkg;

    localparam int COORD_WIDTH          = 32;
    localparam int DEF_ROTATION_STAGES  = 16;
    localparam int MAX_ROTATION_STAGES  = 32;
    localparam int CMD_W                = 2;
    localparam int K_W                  = 16;
    localparam int K_FRAC               = 8;
    localparam int ANG_W                = 16;
    localparam int Z_W                  = 32;
    localparam int GUARD                = 8;
    localparam int GAIN_BITS            = 30;
    localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'd652032874;
    localparam int SPLIT                = 16;

    // datapath widths
    localparam int D_W    = COORD_WIDTH + 1;
    localparam int PH_W   = D_W - SPLIT + GAIN_BITS + 1;
    localparam int PL_W   = SPLIT + GAIN_BITS;
    localparam int PROD_W = PH_W + SPLIT;
    localparam int G_W    = PROD_W - (GAIN_BITS - GUARD);
    localparam int X_W    = G_W + 2;
    localparam int SP_W   = D_W + K_W;
    localparam int ALT_W  = SP_W - K_FRAC + 1;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCALE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROTATE    = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]              command;
        logic signed [COORD_WIDTH-1:0] centre_x;
        logic signed [COORD_WIDTH-1:0] centre_y;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] offset_x;
        logic signed [COORD_WIDTH-1:0] offset_y;
        logic signed [K_W-1:0]         scale_factor;
        logic [ANG_W-1:0]              turn_angle;
    } t_prst_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] new_x;
        logic signed [COORD_WIDTH-1:0] new_y;
        logic                          saturated;
    } t_prst_out;

    // word moving down the cell chain
    typedef struct packed {
        logic                          valid;
        logic [CMD_W-1:0]              cmd;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [ALT_W-1:0]       alt_x;
        logic signed [ALT_W-1:0]       alt_y;
        logic signed [X_W-1:0]         x;
        logic signed [X_W-1:0]         y;
        logic signed [Z_W-1:0]         z;
    } t_prst_cell;

    // arctangent of 2^-idx in units of 2^-32 turn
    function automatic logic [Z_W-1:0] atan_turn(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051D;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/prst_prep.sv =====
// ----------------------------------------------------------------------------
// prst_prep: front end of the transform pipeline
// Forms differences and sums, the gain and scale products, and the quadrant
// pre-rotation, then hands a word to the first cordic cell.
// ----------------------------------------------------------------------------
module prst_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  prst_pkg::t_prst_in    i_cmd,
    output prst_pkg::t_prst_cell  o_cell
);
    import prst_pkg::*;

    localparam logic [1:0] QUAD_LEFT = 2'd1;
    localparam logic [1:0] QUAD_BACK = 2'd2;
    localparam logic [1:0] QUAD_RIGHT = 2'd3;
    localparam logic [ANG_W-1:0] EIGHTH_TURN = ANG_W'(1) << (ANG_W - 3);
    localparam logic signed [GAIN_BITS:0] GAIN_S = {1'b0, GAIN_Q30};

    // stage a
    logic                          r_a_valid;
    logic [CMD_W-1:0]              r_a_cmd;
    logic signed [COORD_WIDTH-1:0] r_a_cx, r_a_cy;
    logic signed [D_W-1:0]         r_a_dx, r_a_dy, r_a_tx, r_a_ty;
    logic signed [K_W-1:0]         r_a_k;
    logic [1:0]                    r_a_q;
    logic signed [Z_W-1:0]         r_a_z;

    // stage b
    logic                          r_b_valid;
    logic [CMD_W-1:0]              r_b_cmd;
    logic signed [COORD_WIDTH-1:0] r_b_cx, r_b_cy;
    logic signed [D_W-1:0]         r_b_tx, r_b_ty;
    logic [1:0]                    r_b_q;
    logic signed [Z_W-1:0]         r_b_z;
    logic signed [PH_W-1:0]        r_b_phx, r_b_phy;
    logic [PL_W-1:0]               r_b_plx, r_b_ply;
    logic signed [SP_W-1:0]        r_b_spx, r_b_spy;

    // stage c
    t_prst_cell                    r_c, n_c;

    logic [ANG_W-1:0]              w_ang_off, w_rem;
    logic [1:0]                    w_q;
    logic signed [D_W-1:0]         w_px, w_py;
    logic signed [D_W-SPLIT-1:0]   w_dhx, w_dhy;
    logic [SPLIT-1:0]              w_dlx, w_dly;
    logic signed [PROD_W-1:0]      w_sumx, w_sumy;
    logic signed [X_W-1:0]         w_gx, w_gy;

    // quadrant nearest the angle, residual within an eighth turn
    always_comb begin
        w_ang_off = i_cmd.turn_angle + EIGHTH_TURN;
        w_q       = w_ang_off[ANG_W-1 -: 2];
        w_rem     = i_cmd.turn_angle - {w_q, {(ANG_W-2){1'b0}}};
        w_px      = D_W'(i_cmd.point_x);
        w_py      = D_W'(i_cmd.point_y);
    end

    always_comb begin
        w_dhx = $signed(r_a_dx[D_W-1:SPLIT]);
        w_dhy = $signed(r_a_dy[D_W-1:SPLIT]);
        w_dlx = r_a_dx[SPLIT-1:0];
        w_dly = r_a_dy[SPLIT-1:0];
    end

    always_comb begin
        w_sumx = $signed({r_b_phx, {SPLIT{1'b0}}})
               + $signed({{(PROD_W-PL_W){1'b0}}, r_b_plx});
        w_sumy = $signed({r_b_phy, {SPLIT{1'b0}}})
               + $signed({{(PROD_W-PL_W){1'b0}}, r_b_ply});
        w_gx   = X_W'($signed(w_sumx[PROD_W-1 -: G_W]));
        w_gy   = X_W'($signed(w_sumy[PROD_W-1 -: G_W]));

        n_c.valid = r_b_valid;
        n_c.cmd   = r_b_cmd;
        n_c.cx    = r_b_cx;
        n_c.cy    = r_b_cy;
        n_c.z     = r_b_z;
        if (r_b_cmd == CMD_SCALE) begin
            n_c.alt_x = ALT_W'($signed(r_b_spx[SP_W-1:K_FRAC])) + ALT_W'(r_b_cx);
            n_c.alt_y = ALT_W'($signed(r_b_spy[SP_W-1:K_FRAC])) + ALT_W'(r_b_cy);
        end else begin
            n_c.alt_x = ALT_W'(r_b_tx);
            n_c.alt_y = ALT_W'(r_b_ty);
        end
        case (r_b_q)
            QUAD_LEFT: begin
                n_c.x = -w_gy;
                n_c.y = w_gx;
            end
            QUAD_BACK: begin
                n_c.x = -w_gx;
                n_c.y = -w_gy;
            end
            QUAD_RIGHT: begin
                n_c.x = w_gy;
                n_c.y = -w_gx;
            end
            default: begin
                n_c.x = w_gx;
                n_c.y = w_gy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c.valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_a_cmd   <= i_cmd.command;
            r_a_cx    <= i_cmd.centre_x;
            r_a_cy    <= i_cmd.centre_y;
            r_a_dx    <= w_px - D_W'(i_cmd.centre_x);
            r_a_dy    <= w_py - D_W'(i_cmd.centre_y);
            if (i_cmd.command == CMD_TRANSLATE) begin
                r_a_tx <= w_px + D_W'(i_cmd.offset_x);
                r_a_ty <= w_py + D_W'(i_cmd.offset_y);
            end else begin
                r_a_tx <= w_px;
                r_a_ty <= w_py;
            end
            r_a_k     <= i_cmd.scale_factor;
            r_a_q     <= w_q;
            r_a_z     <= $signed({w_rem, {(Z_W-ANG_W){1'b0}}});

            r_b_valid <= r_a_valid;
            r_b_cmd   <= r_a_cmd;
            r_b_cx    <= r_a_cx;
            r_b_cy    <= r_a_cy;
            r_b_tx    <= r_a_tx;
            r_b_ty    <= r_a_ty;
            r_b_q     <= r_a_q;
            r_b_z     <= r_a_z;
            // gain product split in two halves
            r_b_phx   <= w_dhx * GAIN_S;
            r_b_phy   <= w_dhy * GAIN_S;
            r_b_plx   <= w_dlx * GAIN_Q30;
            r_b_ply   <= w_dly * GAIN_Q30;
            r_b_spx   <= r_a_dx * r_a_k;
            r_b_spy   <= r_a_dy * r_a_k;

            r_c       <= n_c;
        end
    end

    assign o_cell = r_c;

endmodule

// ===== rtl/prst_cell.sv =====
// ----------------------------------------------------------------------------
// prst_cell: one cordic micro-rotation cell
// Rotates the vector by plus or minus atan(2^-STAGE) toward zero residual
// angle and passes the rest of the word along unchanged.
// ----------------------------------------------------------------------------
module prst_cell #(
    parameter int STAGE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  prst_pkg::t_prst_cell  i_cell,
    output prst_pkg::t_prst_cell  o_cell
);
    import prst_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_turn(STAGE);

    t_prst_cell            r_q, n_q;
    logic signed [X_W-1:0] w_x, w_y, w_xs, w_ys;

    always_comb begin
        w_x  = i_cell.x;
        w_y  = i_cell.y;
        w_xs = w_x >>> STAGE;
        w_ys = w_y >>> STAGE;
        n_q  = i_cell;
        if (!i_cell.z[Z_W-1]) begin
            n_q.x = w_x - w_ys;
            n_q.y = w_y + w_xs;
            n_q.z = i_cell.z - ATAN;
        end else begin
            n_q.x = w_x + w_ys;
            n_q.y = w_y - w_xs;
            n_q.z = i_cell.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_cell = r_q;

    // residual angle stays well inside a quarter turn
    a_z_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q.valid && r_q.cmd == CMD_ROTATE) |-> (r_q.z[Z_W-1] == r_q.z[Z_W-2]))
        else $error("cordic residual angle out of range");

    // vector growth never reaches the top bit
    a_xy_headroom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q.valid && r_q.cmd == CMD_ROTATE) |->
            (r_q.x[X_W-1] == r_q.x[X_W-2] && r_q.y[X_W-1] == r_q.y[X_W-2]))
        else $error("cordic vector overflow");

endmodule

// ===== rtl/point_rotate_scale_translate.sv =====
// ----------------------------------------------------------------------------
// point_rotate_scale_translate: translate, scale or rotate a 2d point
// Pipeline: three front stages, one cordic cell per rotation stage (capped at
// MAX_ROTATION_STAGES), then the round and clip stages. Throughput: one word
// every cycle while busy is low.
// Reset: clears the valid bits of every stage; busy is high during reset and
// for the first cycle after it. The receiver cannot stall, so busy is
// otherwise always low.
// ----------------------------------------------------------------------------
module point_rotate_scale_translate #(
    parameter int ROTATION_STAGES = prst_pkg::DEF_ROTATION_STAGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  prst_pkg::t_prst_in  i_cmd,
    output logic                o_valid,
    output prst_pkg::t_prst_out o_result
);
    import prst_pkg::*;

    localparam int N_CELLS = (ROTATION_STAGES > MAX_ROTATION_STAGES) ?
                             MAX_ROTATION_STAGES : ROTATION_STAGES;
    localparam int LATENCY = N_CELLS + 5;
    localparam logic [GUARD-1:0] HALF = {1'b1, {(GUARD-1){1'b0}}};

    t_prst_cell                w_chain [N_CELLS+1];
    logic                      r_busy;
    logic                      w_accept;

    logic                      r_s_valid;
    logic signed [ALT_W-1:0]   r_s_x, r_s_y;
    logic signed [X_W:0]       w_rsum_x, w_rsum_y;
    logic                      r_out_valid;
    t_prst_out                 r_out, n_out;
    logic [COORD_WIDTH:0]      w_clip_x, w_clip_y;

    function automatic logic [COORD_WIDTH:0] clip_coord(input logic signed [ALT_W-1:0] v);
        logic [ALT_W-COORD_WIDTH:0] top;
        logic [COORD_WIDTH:0]       res;
        top = v[ALT_W-1:COORD_WIDTH-1];
        if (&top || ~|top) begin
            res = {1'b0, v[COORD_WIDTH-1:0]};
        end else if (v[ALT_W-1]) begin
            res = {1'b1, COORD_MIN};
        end else begin
            res = {1'b1, COORD_MAX};
        end
        return res;
    endfunction

    assign w_accept = start && !busy;

    prst_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_cmd   (i_cmd),
        .o_cell  (w_chain[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        prst_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // round to nearest and add the centre in one sum
    always_comb begin
        w_rsum_x = (X_W+1)'(w_chain[N_CELLS].x)
                 + (X_W+1)'($signed({w_chain[N_CELLS].cx, HALF}));
        w_rsum_y = (X_W+1)'(w_chain[N_CELLS].y)
                 + (X_W+1)'($signed({w_chain[N_CELLS].cy, HALF}));
    end

    always_comb begin
        w_clip_x        = clip_coord(r_s_x);
        w_clip_y        = clip_coord(r_s_y);
        n_out.new_x     = w_clip_x[COORD_WIDTH-1:0];
        n_out.new_y     = w_clip_y[COORD_WIDTH-1:0];
        n_out.saturated = w_clip_x[COORD_WIDTH] | w_clip_y[COORD_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_s_valid   <= w_chain[N_CELLS].valid;
            if (w_chain[N_CELLS].cmd == CMD_ROTATE) begin
                r_s_x <= ALT_W'($signed(w_rsum_x[X_W:GUARD]));
                r_s_y <= ALT_W'($signed(w_rsum_y[X_W:GUARD]));
            end else begin
                r_s_x <= w_chain[N_CELLS].alt_x;
                r_s_y <= w_chain[N_CELLS].alt_y;
            end
            r_out_valid <= r_s_valid;
            r_out       <= n_out;
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("result strobe missing after accepted word");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.new_x == COORD_MAX || o_result.new_x == COORD_MIN ||
             o_result.new_y == COORD_MAX || o_result.new_y == COORD_MIN))
        else $error("saturated flag without a clipped coordinate");

    a_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");

endmodule
